// ===== hw/rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic Lagrange interpolator package
// Shared widths, codes, command and status structures, and the factorial
// helper that the datapath uses to build its denominator tables.
// ----------------------------------------------------------------------------
package pli_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_POINTS_DEF   = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // The weight arithmetic is sized for this order, so it is fixed.
    localparam int MAX_ORDER = 7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INV_SPACING  = 2'd0;
    localparam logic [1:0] CFG_GRID_SIZE    = 2'd1;
    localparam logic [1:0] CFG_INTERP_ORDER = 2'd2;

    // Request function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Internal widths.
    localparam int N_W       = 11;  // grid size and wrapped index
    localparam int ORD_W     = 3;   // order
    localparam int HALF_W    = 2;   // order / 2
    localparam int NUM_W     = 28;  // basis numerator, signed Q16
    localparam int FAC_W     = 21;  // (t - node) factor, signed Q16
    localparam int NP_W      = 29;  // rounded dividend magnitude
    localparam int W_W       = 28;  // weight, signed Q16
    localparam int D_W       = 13;  // denominator magnitude
    localparam int R_W       = 33;  // reciprocal, floor(2^32 / d)
    localparam int MB_W      = 34;  // second multiplier operand
    localparam int MAG_W     = 33;  // magnitude fed to the wrap unit
    localparam int MOD_STEPS = 33;  // one remainder step per magnitude bit
    localparam int ITER_W    = 6;

    localparam int Q16_ONE  = 65536;
    localparam int Q16_HALF = 32768;

    typedef enum logic [2:0] {
        MUL_POS,
        MUL_FACT,
        MUL_RECIP,
        MUL_CORR,
        MUL_ACC
    } mul_sel_t;

    typedef struct packed {
        logic             wr_sample;
        logic             load_query;
        logic             mul_en;
        mul_sel_t         mul_sel;
        logic             split;
        logic             mod_step;
        logic             mod_fix;
        logic             k_init;
        logic             num_upd;
        logic             div_np;
        logic             div_q0;
        logic             div_w;
        logic             acc_add;
        logic             round;
        logic             load_out;
        logic [ORD_W-1:0] k;
        logic [ORD_W-1:0] m;
    } pli_cmd_t;

    typedef struct packed {
        logic             size_err;
        logic [ORD_W-1:0] order;
    } pli_status_t;

    function automatic int unsigned fact(input int unsigned x);
        int unsigned r;
        r = 1;
        for (int unsigned i = 2; i <= x; i++)
        begin
            r = r * i;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pli_ctrl.sv =====
// ----------------------------------------------------------------------------
// Periodic Lagrange interpolator controller
// Sequences each query through the shared multiplier and the wrap unit,
// and owns the request handshakes.
// ----------------------------------------------------------------------------
module pli_ctrl
    import pli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        func,
    input  logic        out_ready,
    input  pli_status_t status,
    output logic        in_ready,
    output logic        out_valid,
    output pli_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_PROD,
        S_SPLIT,
        S_MOD,
        S_MODFIX,
        S_KINIT,
        S_FACT,
        S_FACTW,
        S_NP,
        S_RMUL,
        S_Q0,
        S_CMUL,
        S_WGT,
        S_AMUL,
        S_ACC,
        S_ROUND,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [ORD_W-1:0]    k_reg, k_next;
    logic [ORD_W:0]      m_reg, m_next;
    logic                in_ready_reg, in_ready_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;

    assign accept    = in_valid && in_ready_reg;
    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_POS;
        cmd.k          = k_reg;
        cmd.m          = m_reg[ORD_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        cmd.wr_sample = 1'b1;
                    end
                    else
                    begin
                        cmd.load_query = 1'b1;
                        in_ready_next  = 1'b0;
                        state_next     = status.size_err ? S_DONE : S_PROD;
                    end
                end
            end
            S_PROD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_POS;
                state_next  = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                iter_next  = '0;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                iter_next    = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(MOD_STEPS - 1))
                begin
                    state_next = S_MODFIX;
                end
            end
            S_MODFIX:
            begin
                cmd.mod_fix = 1'b1;
                k_next      = '0;
                state_next  = S_KINIT;
            end
            S_KINIT:
            begin
                cmd.k_init = 1'b1;
                m_next     = '0;
                state_next = S_FACT;
            end
            S_FACT:
            begin
                if (m_reg > {1'b0, status.order})
                begin
                    state_next = S_NP;
                end
                else if (m_reg[ORD_W-1:0] == k_reg)
                begin
                    m_next = m_reg + (ORD_W+1)'(1);
                end
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_FACT;
                    state_next  = S_FACTW;
                end
            end
            S_FACTW:
            begin
                cmd.num_upd = 1'b1;
                m_next      = m_reg + (ORD_W+1)'(1);
                state_next  = S_FACT;
            end
            S_NP:
            begin
                cmd.div_np = 1'b1;
                state_next = S_RMUL;
            end
            S_RMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RECIP;
                state_next  = S_Q0;
            end
            S_Q0:
            begin
                cmd.div_q0 = 1'b1;
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CORR;
                state_next  = S_WGT;
            end
            S_WGT:
            begin
                cmd.div_w  = 1'b1;
                state_next = S_AMUL;
            end
            S_AMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ACC;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (k_reg == status.order)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    k_next     = k_reg + ORD_W'(1);
                    state_next = S_KINIT;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    in_ready_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The stencil counter never runs past the order while factors are formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FACT) |-> (k_reg <= status.order))
        else $error("stencil counter beyond order");

    // A result only appears from the completion state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    // A query closes the input until its result is produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_QUERY) |=> !in_ready_reg)
        else $error("input still open after query");

endmodule

// ===== hw/rtl/pli_datapath.sv =====
// ----------------------------------------------------------------------------
// Periodic Lagrange interpolator datapath
// Configuration registers, sample memory, shared multiplier, wrap unit,
// weight rounding and accumulator.
// ----------------------------------------------------------------------------
module pli_datapath
    import pli_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic [9:0]         sample_index,
    input  logic signed [31:0] sample_value,
    input  logic signed [31:0] position,
    input  pli_cmd_t           cmd,
    output pli_status_t        status,
    output logic signed [31:0] interp_value,
    output logic               size_error
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int MA    = (SAMPLE_WIDTH > 33) ? SAMPLE_WIDTH : 33;
    localparam int PW    = MA + MB_W;
    localparam int ACC_W = (SAMPLE_WIDTH + 31 > 49) ? SAMPLE_WIDTH + 31 : 49;
    localparam int XW    = (SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32;

    // Configuration
    logic [31:0]       inv_spacing_reg;
    logic [N_W-1:0]    grid_size_reg;
    logic [ORD_W-1:0]  interp_order_reg;

    logic [N_W-1:0]    n_eff;
    logic [ORD_W-1:0]  order_eff;
    logic [HALF_W-1:0] half;

    // Sample memory
    logic signed [SAMPLE_WIDTH-1:0] mem [MAX_POINTS];
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [XW-1:0]           sample_ext;
    logic                           wr_ok;

    // Working registers
    logic signed [31:0]       pos_reg;
    logic                     err_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [MA-1:0]     mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic [15:0]              t_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic                     v_neg_reg;
    logic [N_W-1:0]           rem_reg;
    logic [N_W-1:0]           idx_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [NP_W-1:0]          np_reg;
    logic [NP_W-1:0]          q0_reg;
    logic                     w_neg_reg;
    logic signed [W_W-1:0]    w_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [31:0]       val_reg;
    logic signed [31:0]       out_value_reg;
    logic                     out_err_reg;

    // Derived combinational values
    logic signed [31:0]       j0;
    logic signed [MAG_W-1:0]  v;
    logic signed [4:0]        node;
    logic signed [FAC_W-1:0]  factor;
    logic [ORD_W-1:0]         bsel;
    logic [D_W-1:0]           d_sel;
    logic [R_W-1:0]           r_sel;
    logic signed [NUM_W:0]    num_ext;
    logic [NUM_W:0]           num_abs;
    logic signed [PW-1:0]     num_rnd;
    logic [N_W:0]             trial;
    logic [NP_W:0]            rem_q;
    logic [NP_W-1:0]          q_sel;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [ACC_W-17:0] rv;
    logic                     sat_pos;
    logic                     sat_neg;

    // Denominator tables: |den| = k! (order-k)! and floor(2^32 / |den|).
    logic [D_W-1:0] d_tab [MAX_ORDER+1][MAX_ORDER+1];
    logic [R_W-1:0] r_tab [MAX_ORDER+1][MAX_ORDER+1];

    for (genvar ga = 0; ga <= MAX_ORDER; ga++)
    begin : g_den_a
        for (genvar gb = 0; gb <= MAX_ORDER; gb++)
        begin : g_den_b
            localparam int unsigned DV =
                (ga + gb <= MAX_ORDER) ? fact(ga) * fact(gb) : 1;
            localparam logic [63:0] RV = (64'd1 << 32) / 64'(DV);
            assign d_tab[ga][gb] = D_W'(DV);
            assign r_tab[ga][gb] = R_W'(RV);
        end
    end

    assign n_eff     = (int'(grid_size_reg) > MAX_POINTS) ? N_W'(MAX_POINTS) : grid_size_reg;
    assign order_eff = (int'(interp_order_reg) > MAX_ORDER) ? ORD_W'(MAX_ORDER)
                                                            : interp_order_reg;
    assign half      = HALF_W'(order_eff >> 1);

    assign status.size_err = n_eff < (N_W'(order_eff) + N_W'(1));
    assign status.order    = order_eff;

    assign sample_ext = XW'(sample_value);
    assign wr_ok      = int'(sample_index) < MAX_POINTS;

    assign j0 = prod_reg[63:32];
    assign v  = $signed({j0[31], j0}) - $signed({{(MAG_W-HALF_W){1'b0}}, half});

    assign node   = $signed({2'b00, cmd.m}) - $signed({3'b000, half});
    assign factor = $signed({5'b00000, t_reg}) - (FAC_W'(node) <<< 16);

    assign bsel  = order_eff - cmd.k;
    assign d_sel = d_tab[cmd.k][bsel];
    assign r_sel = r_tab[cmd.k][bsel];

    assign num_ext = (NUM_W+1)'(num_reg);
    assign num_abs = num_ext[NUM_W] ? (NUM_W+1)'(-num_ext) : num_ext;
    assign num_rnd = prod_reg + PW'(Q16_HALF);

    assign trial = {rem_reg, mag_reg[MAG_W-1]};

    assign rem_q = {1'b0, np_reg} - prod_reg[NP_W:0];
    assign q_sel = (rem_q >= (NP_W+1)'(d_sel)) ? q0_reg + NP_W'(1) : q0_reg;

    assign acc_rnd = acc_reg + ACC_W'(Q16_HALF);
    assign rv      = acc_rnd[ACC_W-1:16];
    assign sat_pos = !rv[ACC_W-17] && (|rv[ACC_W-18:31]);
    assign sat_neg = rv[ACC_W-17] && !(&rv[ACC_W-18:31]);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_POS:
            begin
                mul_a = MA'(pos_reg);
                mul_b = $signed({2'b00, inv_spacing_reg});
            end
            MUL_FACT:
            begin
                mul_a = MA'(factor);
                mul_b = MB_W'(num_reg);
            end
            MUL_RECIP:
            begin
                mul_a = MA'($signed({1'b0, np_reg}));
                mul_b = $signed({1'b0, r_sel});
            end
            MUL_CORR:
            begin
                mul_a = MA'($signed({1'b0, q0_reg}));
                mul_b = MB_W'($signed({1'b0, d_sel}));
            end
            MUL_ACC:
            begin
                mul_a = MA'(y_reg);
                mul_b = MB_W'(w_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_spacing_reg  <= 32'd65536;
            grid_size_reg    <= N_W'(1024);
            interp_order_reg <= ORD_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INV_SPACING:  inv_spacing_reg  <= cfg_data;
                CFG_GRID_SIZE:    grid_size_reg    <= cfg_data[N_W-1:0];
                CFG_INTERP_ORDER: interp_order_reg <= cfg_data[ORD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_sample && wr_ok)
        begin
            mem[AW'(sample_index)] <= sample_ext[SAMPLE_WIDTH-1:0];
        end
        if (cmd.k_init)
        begin
            y_reg <= mem[AW'(idx_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            pos_reg <= position;
            err_reg <= status.size_err;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PW'(mul_a) * PW'(mul_b);
        end
        if (cmd.split)
        begin
            t_reg     <= prod_reg[31:16];
            v_neg_reg <= v[MAG_W-1];
            mag_reg   <= v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
            rem_reg   <= '0;
        end
        if (cmd.mod_step)
        begin
            mag_reg <= {mag_reg[MAG_W-2:0], 1'b0};
            rem_reg <= (trial >= {1'b0, n_eff}) ? N_W'(trial - {1'b0, n_eff})
                                                : N_W'(trial);
        end
        if (cmd.mod_fix)
        begin
            idx_reg <= (v_neg_reg && rem_reg != '0) ? n_eff - rem_reg : rem_reg;
            acc_reg <= '0;
        end
        if (cmd.k_init)
        begin
            num_reg <= NUM_W'(Q16_ONE);
        end
        if (cmd.num_upd)
        begin
            num_reg <= num_rnd[16 +: NUM_W];
        end
        if (cmd.div_np)
        begin
            np_reg    <= NP_W'(num_abs) + NP_W'(d_sel >> 1);
            w_neg_reg <= num_reg[NUM_W-1] ^ bsel[0];
        end
        if (cmd.div_q0)
        begin
            q0_reg <= prod_reg[32 +: NP_W];
        end
        if (cmd.div_w)
        begin
            w_reg <= w_neg_reg ? -W_W'(q_sel) : W_W'(q_sel);
        end
        if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
            idx_reg <= (idx_reg + N_W'(1) == n_eff) ? '0 : idx_reg + N_W'(1);
        end
        if (cmd.round)
        begin
            if (sat_pos)
            begin
                val_reg <= 32'sh7FFF_FFFF;
            end
            else if (sat_neg)
            begin
                val_reg <= 32'sh8000_0000;
            end
            else
            begin
                val_reg <= rv[31:0];
            end
        end
        if (cmd.load_out)
        begin
            out_value_reg <= err_reg ? '0 : val_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign interp_value = out_value_reg;
    assign size_error   = out_err_reg;

    // The running remainder always stays below the period.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_step |-> (rem_reg < n_eff))
        else $error("wrap remainder not below grid size");

    // Every stencil read lands inside the grid in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.k_init |-> (idx_reg < n_eff))
        else $error("stencil index outside grid");

endmodule

// ===== hw/rtl/periodic_lagrange_interpolator.sv =====
// ----------------------------------------------------------------------------
// Periodic Lagrange interpolator
// Stores a periodic uniform grid of samples and answers interpolation
// queries with a local Lagrange polynomial of configurable order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Carries
//  input     in         in_valid/in_ready    func, sample_index, sample_value,
//                                            position
//  output    out        out_valid/out_ready  interp_value, size_error
//  config    in         cfg_we               cfg_index, cfg_data
//
// A sample write produces no result and leaves the input open.
// A query passes first through the position multiply and the serial wrap
// unit, then per stencil point one multiplier pass for each basis factor
// plus the weight division and the accumulate, all through the one shared
// multiplier. A grid too small for the order skips the arithmetic.
// Reset is asynchronous and restores the configuration defaults; the sample
// memory is not cleared and must be written before it is read.
// A stalled output holds the finished result; sample writes and a new query
// are still taken while it waits, and the new result waits behind it.
// ----------------------------------------------------------------------------
module periodic_lagrange_interpolator
    import pli_pkg::*;
#(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [9:0]         sample_index,
    input  logic signed [31:0] sample_value,
    input  logic signed [31:0] position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] interp_value,
    output logic               size_error
);

    // The controller sequences every request; the datapath holds the grid,
    // the configuration and all arithmetic, and reports the order and the
    // size check back.
    pli_cmd_t    cmd;
    pli_status_t status;

    pli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    pli_datapath #(
        .MAX_POINTS   (MAX_POINTS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .position     (position),
        .cmd          (cmd),
        .status       (status),
        .interp_value (interp_value),
        .size_error   (size_error)
    );

endmodule
